>>> hw/rtl/cti_pkg.sv
// shared types and constants for the calibration time interval lookup
// no dependencies; imported by cti_ctrl, cti_dp, cti_chk and the top level
`default_nettype none

package cti_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);

  localparam int YEAR_W  = 14;
  localparam int DAY_W   = 9;
  localparam int MSEC_W  = 27;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = 6;
  localparam int CFG_W   = 7;
  localparam int YADJ_W  = YEAR_W + 1;
  localparam int CLAMP_W = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;

  localparam logic [MSEC_W-1:0] HALF_DAY_MS = MSEC_W'(43200000);

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 56;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [MSEC_W-1:0] end_msec;
    logic [DAY_W-1:0]  end_day;
    logic [YEAR_W-1:0] end_year;
    logic [MSEC_W-1:0] start_msec;
    logic [DAY_W-1:0]  start_day;
    logic [YEAR_W-1:0] start_year;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic wr;       // load word accepted
    logic start;    // query word accepted
    logic step;     // move to next lower slot
    logic hit;      // capture current slot as result
    logic publish;  // move result into output register
  } cti_cmd_t;

  typedef struct packed {
    logic match;
    logic last;
    logic empty;
  } cti_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/cti_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/cti_ctrl.sv
// controller state machine: accepts words, sequences the slot scan, output valid
// depends on cti_pkg
`default_nettype none

module cti_ctrl
  import cti_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire cti_sts_t sts,
  output cti_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.wr      = acc && (in_op == OP_LOAD);
    cmd.start   = acc && (in_op == OP_QUERY);
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = sts.empty ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.match || sts.last) begin
          cmd.hit   = sts.match;
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cti_dp.sv
// datapath: slot table, entry count register, query time adjust, interval compare
// depends on cti_pkg and cti_ram
`default_nettype none

module cti_dp
  import cti_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire cti_cmd_t              cmd,
  output cti_sts_t                   sts,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic                       out_found
);

  logic [CFG_W-1:0]   entry_count_r;
  logic [CLAMP_W-1:0] cnt_ext, n_clamp;
  logic [ADDR_W-1:0]  start_idx;

  logic [SLOT_W-1:0]  in_slot;
  entry_t             in_entry;
  logic [YEAR_W-1:0]  q_year;
  logic [DAY_W-1:0]   q_sday, q_eday, d_adj;
  logic [MSEC_W-1:0]  q_msec;

  logic [YADJ_W-1:0]  y_r;
  logic [DAY_W-1:0]   d_r;
  logic [MSEC_W-1:0]  ms_r;
  logic [ADDR_W-1:0]  idx_r;

  logic               ram_we;
  logic [ADDR_W-1:0]  raddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t             ent;

  logic [YADJ_W-1:0]  sy, ey;
  logic               before_end, match;

  logic               res_found_r;
  logic [IDX_W-1:0]   res_idx_r;
  logic [YEAR_W-1:0]  res_year_r;
  logic [DAY_W-1:0]   res_day_r;
  logic [MSEC_W-1:0]  res_msec_r;

  logic               out_found_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // input word unpacking
  assign in_slot             = in_data[5:0];
  assign in_entry.start_year = in_data[19:6];
  assign in_entry.start_day  = in_data[28:20];
  assign in_entry.start_msec = in_data[55:29];
  assign in_entry.end_year   = in_data[69:56];
  assign in_entry.end_day    = in_data[78:70];
  assign in_entry.end_msec   = in_data[105:79];
  assign q_year              = in_data[119:106];
  assign q_sday              = in_data[128:120];
  assign q_eday              = in_data[137:129];
  assign q_msec              = in_data[164:138];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_data;
    end
  end

  assign cnt_ext   = CLAMP_W'(entry_count_r);
  assign n_clamp   = (cnt_ext > CLAMP_W'(MAX_ENTRIES)) ? CLAMP_W'(MAX_ENTRIES) : cnt_ext;
  assign start_idx = ADDR_W'(n_clamp - CLAMP_W'(1));

  // late half of a day-spanning granule takes the end day
  assign d_adj = (q_sday != q_eday && q_msec < HALF_DAY_MS) ? q_eday : q_sday;

  assign ram_we = cmd.wr && (32'(in_slot) < MAX_ENTRIES);
  assign raddr  = cmd.start ? start_idx : idx_r - ADDR_W'(1);

  cti_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_slot)),
    .wdata (in_entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      y_r   <= YADJ_W'(q_year) + YADJ_W'(d_adj < q_sday);
      d_r   <= d_adj;
      ms_r  <= q_msec;
      idx_r <= start_idx;
    end else if (cmd.step) begin
      idx_r <= idx_r - ADDR_W'(1);
    end
  end

  // interval compare on the slot read last cycle
  assign ent = entry_t'(rdata);
  assign sy  = YADJ_W'(ent.start_year);
  assign ey  = YADJ_W'(ent.end_year);
  assign before_end = (d_r < ent.end_day) || (d_r == ent.end_day && ms_r <= ent.end_msec);

  always_comb begin
    if (ent.end_year == '0) begin
      match = (y_r > sy) || (y_r == sy && d_r > ent.start_day) ||
              (y_r == sy && d_r == ent.start_day && ms_r >= ent.start_msec);
    end else if (y_r > sy) begin
      match = (y_r < ey) || (y_r == ey && before_end);
    end else if (y_r == sy) begin
      // start msec deliberately not checked
      match = (y_r < ey) || (y_r == ey && d_r >= ent.start_day && before_end);
    end else begin
      match = 1'b0;
    end
  end

  assign sts.match = match;
  assign sts.last  = (idx_r == '0);
  assign sts.empty = (n_clamp == '0);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
      res_year_r  <= '0;
      res_day_r   <= '0;
      res_msec_r  <= '0;
    end else if (cmd.hit) begin
      res_found_r <= 1'b1;
      res_idx_r   <= IDX_W'(idx_r);
      res_year_r  <= ent.start_year;
      res_day_r   <= ent.start_day;
      res_msec_r  <= ent.start_msec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_found_r <= res_found_r;
      out_data_r  <= {res_msec_r, res_day_r, res_year_r, res_idx_r};
    end
  end

  assign out_found = out_found_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/calibration_time_interval_lookup.sv
// calibration time interval lookup top level: controller and datapath; needs cti_pkg, cti_ctrl, cti_dp
// load word: written into its slot, no result
// query word: up to min(entry_count,64) slots compared one per cycle, the hit captured in the result
// register, then moved into the output register; no new word is taken until the result is published
// a stalled result word holds the block in its done state until out_tready
// reset clears entry count, state machine and output valid; table undefined until loaded
`default_nettype none

module calibration_time_interval_lookup
  import cti_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data,      // entry_count
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // entry_slot, entry_start_year, entry_start_day, entry_start_msec, entry_end_year,
  // entry_end_day, entry_end_msec, query_year, query_start_day, query_end_day,
  // query_msec, zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,      // operation
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,     // match_index, match_year, match_day, match_msec
  output logic                       out_tuser      // found
);

  cti_cmd_t cmd;
  cti_sts_t sts;

  assign cfg_ready = 1'b1;

  cti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cti_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata),
    .out_found (out_tuser)
  );

endmodule

`default_nettype wire

>>> hw/rtl/cti_chk.sv
// port level checker for the lookup top level, bound in below
// depends on cti_pkg
`default_nettype none

module cti_chk
  import cti_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // a miss carries all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result with nonzero fields");

  // a query keeps the input closed while the scan runs
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_QUERY |=> !in_tready)
    else $error("input reopened during a query");

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind calibration_time_interval_lookup cti_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

>>> test/testbench.sv
// self-checking testbench for calibration_time_interval_lookup: loads interval
// tables, sends queries and compares every result word against a local predictor
// depends on cti_pkg and the calibration_time_interval_lookup rtl
`default_nettype none

module testbench;
  import cti_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int YEAR_MAX = 9999;
  localparam int DAY_MAX  = 366;
  localparam int MSEC_MAX = 86399999;

  localparam int M_YEAR_LSB = IDX_W;
  localparam int M_DAY_LSB  = IDX_W + YEAR_W;
  localparam int M_MSEC_LSB = IDX_W + YEAR_W + DAY_W;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    entry_t            ent;
    logic [YEAR_W-1:0] q_year;
    logic [DAY_W-1:0]  q_start_day;
    logic [DAY_W-1:0]  q_end_day;
    logic [MSEC_W-1:0] q_msec;
  } cal_word_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  slot_idx;
    logic [YEAR_W-1:0] year;
    logic [DAY_W-1:0]  day;
    logic [MSEC_W-1:0] msec;
  } match_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  calibration_time_interval_lookup u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predictor state, updated as words are accepted
  entry_t       cal_table [MAX_ENTRIES];
  int unsigned  slots_in_use = 0;
  match_t       match_queue[$];

  // generator side: what the table will hold once queued loads are taken
  entry_t       plan_table [MAX_ENTRIES];
  bit           plan_written [MAX_ENTRIES];
  cal_word_t    word_queue[$];

  int           err_cnt = 0;
  int           issued  = 0;

  cal_word_t    tx_word = '0;
  bit           tx_busy = 1'b0;
  bit           tx_calm = 1'b0;
  int           tx_gap  = 0;
  bit           rx_calm = 1'b0;
  int           rx_gap  = 0;
  match_t       want;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic int pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic int rand_msec();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return HALF_DAY_MS - 1;
      2:       return HALF_DAY_MS;
      3:       return MSEC_MAX;
      default: return $urandom_range(0, MSEC_MAX);
    endcase
  endfunction

  // every field random within its range; the fields the operation ignores keep it
  function automatic cal_word_t noise_word();
    cal_word_t w;
    w.op             = OP_LOAD;
    w.slot           = SLOT_W'($urandom_range(0, MAX_ENTRIES - 1));
    w.ent.start_year = YEAR_W'($urandom_range(0, YEAR_MAX));
    w.ent.start_day  = DAY_W'($urandom_range(0, DAY_MAX));
    w.ent.start_msec = MSEC_W'($urandom_range(0, MSEC_MAX));
    w.ent.end_year   = YEAR_W'($urandom_range(0, YEAR_MAX));
    w.ent.end_day    = DAY_W'($urandom_range(0, DAY_MAX));
    w.ent.end_msec   = MSEC_W'($urandom_range(0, MSEC_MAX));
    w.q_year         = YEAR_W'($urandom_range(0, YEAR_MAX));
    w.q_start_day    = DAY_W'($urandom_range(0, DAY_MAX));
    w.q_end_day      = DAY_W'($urandom_range(0, DAY_MAX));
    w.q_msec         = MSEC_W'($urandom_range(0, MSEC_MAX));
    return w;
  endfunction

  task automatic push_load(input int slot, input int sy, input int sd, input int sm,
                           input int ey, input int ed, input int em);
    cal_word_t w;
    w = noise_word();
    w.op             = OP_LOAD;
    w.slot           = SLOT_W'(slot);
    w.ent.start_year = YEAR_W'(sy);
    w.ent.start_day  = DAY_W'(sd);
    w.ent.start_msec = MSEC_W'(sm);
    w.ent.end_year   = YEAR_W'(ey);
    w.ent.end_day    = DAY_W'(ed);
    w.ent.end_msec   = MSEC_W'(em);
    plan_table[slot]   = w.ent;
    plan_written[slot] = 1'b1;
    word_queue.push_back(w);
    issued++;
  endtask

  task automatic push_query(input int y, input int sd, input int ed, input int ms);
    cal_word_t w;
    w = noise_word();
    w.op          = OP_QUERY;
    w.q_year      = YEAR_W'(y);
    w.q_start_day = DAY_W'(sd);
    w.q_end_day   = DAY_W'(ed);
    w.q_msec      = MSEC_W'(ms);
    word_queue.push_back(w);
    issued++;
  endtask

  // intervals clustered a few years around base so that queries land inside them
  task automatic push_random_load(input int slot, input int base);
    int sy;
    int ey;
    sy = clamp(base + $urandom_range(0, 3), YEAR_MAX);
    case ($urandom_range(0, 3))
      0:       ey = 0;
      1:       ey = sy;
      2:       ey = clamp(sy + $urandom_range(1, 2), YEAR_MAX);
      default: ey = $urandom_range(0, YEAR_MAX);
    endcase
    push_load(slot, sy, $urandom_range(0, DAY_MAX), rand_msec(),
              ey, $urandom_range(0, DAY_MAX), rand_msec());
  endtask

  task automatic push_random_query(input int base);
    int     k;
    int     y;
    int     sd;
    int     ed;
    int     ms;
    int     nudge;
    entry_t e;
    k = $urandom_range(0, MAX_ENTRIES - 1);
    if ($urandom_range(0, 9) < 4 && plan_written[k]) begin
      // aim at a start or end boundary of a loaded slot, one step either side
      e = plan_table[k];
      if ($urandom_range(0, 1) == 1) begin
        y = e.start_year; sd = e.start_day; ms = e.start_msec;
      end else begin
        y = e.end_year; sd = e.end_day; ms = e.end_msec;
      end
      nudge = $urandom_range(0, 2);
      sd = clamp(sd + nudge - 1, DAY_MAX);
      nudge = $urandom_range(0, 2);
      ms = clamp(ms + nudge - 1, MSEC_MAX);
      ed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DAY_MAX) : sd;
    end else begin
      y  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, YEAR_MAX)
                                       : clamp(base - 1 + $urandom_range(0, 5), YEAR_MAX);
      sd = $urandom_range(0, DAY_MAX);
      ms = rand_msec();
      case ($urandom_range(0, 3))
        0: ed = sd;
        1: ed = $urandom_range(0, DAY_MAX);
        2: ed = clamp(sd + $urandom_range(1, 3), DAY_MAX);
        default: begin
          // data spans new year
          sd = $urandom_range(360, DAY_MAX);
          ed = $urandom_range(0, 5);
        end
      endcase
    end
    push_query(y, sd, ed, ms);
  endtask

  // predicted result of one query against the current table
  function automatic match_t lookup_interval(input cal_word_t w);
    logic [YADJ_W-1:0] y;
    logic [DAY_W-1:0]  d;
    logic [MSEC_W-1:0] ms;
    logic              in_end;
    logic              hit;
    int                n;
    entry_t            e;
    match_t            r;
    r  = '0;
    y  = YADJ_W'(w.q_year);
    d  = w.q_start_day;
    ms = w.q_msec;
    if (w.q_start_day != w.q_end_day && w.q_msec < HALF_DAY_MS) d = w.q_end_day;
    if (d < w.q_start_day) y = y + 1'b1;
    n = (slots_in_use > MAX_ENTRIES) ? MAX_ENTRIES : slots_in_use;
    for (int k = n - 1; k >= 0; k--) begin
      e = cal_table[k];
      in_end = (d < e.end_day) || (d == e.end_day && ms <= e.end_msec);
      if (e.end_year == '0) begin
        // onwards interval
        hit = (y > e.start_year) ||
              (y == e.start_year && (d > e.start_day ||
                                     (d == e.start_day && ms >= e.start_msec)));
      end else if (y > e.start_year) begin
        hit = (y < e.end_year) || (y == e.end_year && in_end);
      end else if (y == e.start_year) begin
        hit = (y < e.end_year) || (y == e.end_year && d >= e.start_day && in_end);
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        r.found    = 1'b1;
        r.slot_idx = IDX_W'(k);
        r.year     = e.start_year;
        r.day      = e.start_day;
        r.msec     = e.start_msec;
        return r;
      end
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      tx_busy = 1'b0;
      tx_gap  = 0;
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (tx_word.op == OP_LOAD) cal_table[tx_word.slot] = tx_word.ent;
        else match_queue.push_back(lookup_interval(tx_word));
        tx_busy = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = pick_wait(tx_calm);
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (word_queue.size() > 0) begin
          tx_word = word_queue.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_tvalid <= tx_busy;
      in_tuser  <= tx_word.op;
      in_tdata  <= {3'b000, tx_word.q_msec, tx_word.q_end_day, tx_word.q_start_day,
                    tx_word.q_year, tx_word.ent, tx_word.slot};
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_gap = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (match_queue.size() == 0) begin
          $error("result word with nothing pending: found %0d tdata %h", out_tuser, out_tdata);
          err_cnt++;
        end else begin
          want = match_queue.pop_front();
          if (out_tuser !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_tuser);
            err_cnt++;
          end
          if (out_tdata[IDX_W-1:0] !== want.slot_idx) begin
            $error("match_index: expected %0d, got %0d", want.slot_idx, out_tdata[IDX_W-1:0]);
            err_cnt++;
          end
          if (out_tdata[M_YEAR_LSB +: YEAR_W] !== want.year) begin
            $error("match_year: expected %0d, got %0d", want.year,
                   out_tdata[M_YEAR_LSB +: YEAR_W]);
            err_cnt++;
          end
          if (out_tdata[M_DAY_LSB +: DAY_W] !== want.day) begin
            $error("match_day: expected %0d, got %0d", want.day, out_tdata[M_DAY_LSB +: DAY_W]);
            err_cnt++;
          end
          if (out_tdata[M_MSEC_LSB +: MSEC_W] !== want.msec) begin
            $error("match_msec: expected %0d, got %0d", want.msec,
                   out_tdata[M_MSEC_LSB +: MSEC_W]);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_gap = pick_wait(rx_calm);
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      out_tready <= (rx_gap == 0);
    end
  end

  // queued words all taken, every result back, then room for a trailing scan
  task automatic wait_drained();
    do @(negedge clk); while (word_queue.size() != 0 || tx_busy || match_queue.size() != 0);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_entry_count(input int n);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(n);
    do @(posedge clk); while (!cfg_ready);
    slots_in_use = n;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    int base;
    int lim;
    int phase;

    for (int k = 0; k < MAX_ENTRIES; k++) plan_written[k] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: queries at the field extremes, then a small known table
    write_entry_count(0);
    push_query(0, 0, 0, 0);
    push_query(YEAR_MAX, DAY_MAX, DAY_MAX, MSEC_MAX);
    push_load(0, 2010, 100, 5000000, 0, 0, 0);
    push_load(1, 2012, 50, 1000, 2012, 200, HALF_DAY_MS);
    push_load(2, 2013, 300, 0, 2015, 10, MSEC_MAX);
    push_load(3, YEAR_MAX, DAY_MAX, MSEC_MAX, 0, DAY_MAX, MSEC_MAX);
    push_load(63, 0, 0, 0, YEAR_MAX, DAY_MAX, MSEC_MAX);
    wait_drained();
    write_entry_count(4);
    push_query(2012, 120, 120, 500);
    push_query(2012, 30, 30, 0);
    push_query(2012, 50, 50, 0);                    // start msec of slot ignored
    push_query(2014, 1, 1, 0);                      // start day ignored after start year
    push_query(2015, 10, 10, MSEC_MAX);             // exactly at end
    push_query(2015, 11, 11, 0);
    push_query(2010, 100, 100, 4999999);            // just before onwards start
    push_query(2010, 100, 100, 5000000);
    push_query(2012, 360, 5, 1000);                 // end day used, year steps up
    push_query(2012, 360, 5, HALF_DAY_MS);          // half day: start day kept
    push_query(2012, 150, 199, HALF_DAY_MS - 1);
    push_query(YEAR_MAX, DAY_MAX, 0, 0);            // year steps past the field range
    push_query(YEAR_MAX, DAY_MAX, DAY_MAX, MSEC_MAX);

    issued = 0;
    phase  = 0;
    while (issued < 1000) begin
      case (phase)
        0: n = 1;
        1: n = MAX_ENTRIES;
        2: n = (1 << CFG_W) - 1;
        default: begin
          case ($urandom_range(0, 9))
            0:       n = MAX_ENTRIES;
            1:       n = $urandom_range(MAX_ENTRIES + 1, (1 << CFG_W) - 1);
            default: n = $urandom_range(0, MAX_ENTRIES);
          endcase
        end
      endcase
      case ($urandom_range(0, 7))
        0:       base = 0;
        1:       base = YEAR_MAX - 2;
        default: base = $urandom_range(0, YEAR_MAX);
      endcase
      wait_drained();
      write_entry_count(n);
      // every slot that a search can reach gets loaded before the first query
      lim = (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
      for (int k = 0; k < lim; k++)
        if (!plan_written[k]) push_random_load(k, base);
      repeat ($urandom_range(30, 70)) begin
        if ($urandom_range(0, 9) < 3) push_random_load($urandom_range(0, MAX_ENTRIES - 1), base);
        else push_random_query(base);
      end
      phase++;
    end

    wait_drained();
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
